// ===== rtl/asa_pkg.sv =====
// ----------------------------------------------------------------------------
// asa_pkg
// Shared types and constants of the aligned stack allocator: command and
// status codes, register indexes, field widths and reset values.
// ----------------------------------------------------------------------------
package asa_pkg;

   // Field widths
   localparam int unsigned OFF_W   = 13;   // pool offsets and sizes
   localparam int unsigned ADDR_W  = 32;   // byte addresses
   localparam int unsigned ADJ_W   = 8;    // stored adjustment, 1 to 128
   localparam int unsigned LG_W    = 3;    // alignment exponent
   localparam int unsigned CMD_W   = 3;
   localparam int unsigned STAT_W  = 2;
   localparam int unsigned CSR_IDX_W = 1;

   // Build defaults
   localparam int unsigned POOL_BYTES_DEFAULT = 4096;
   localparam logic [LG_W-1:0] MAX_ALIGN_LOG2 = 3'd7;

   // Register reset values
   localparam logic [ADDR_W-1:0] BASE_ADDRESS_RESET = '0;
   localparam logic [OFF_W-1:0]  POOL_SIZE_RESET    = 13'd4096;

   typedef enum logic [CMD_W-1:0] {
      CMD_ALLOC     = 3'd0,
      CMD_DEALLOC   = 3'd1,
      CMD_RESET     = 3'd2,
      CMD_MARK      = 3'd3,
      CMD_FREE_MARK = 3'd4,
      CMD_SET_MARK  = 3'd5
   } cmd_type;

   typedef enum logic [STAT_W-1:0] {
      ST_OK       = 2'd0,
      ST_NO_SPACE = 2'd1,
      ST_BAD_ADDR = 2'd2,
      ST_BAD_MARK = 2'd3
   } status_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_BASE_ADDRESS = 1'd0,
      CSR_POOL_SIZE    = 1'd1
   } csr_index_type;

endpackage

// ===== rtl/asa_ram.sv =====
// ----------------------------------------------------------------------------
// asa_ram
// Generic single-clock RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module asa_ram #(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/aligned_stack_allocator.sv =====
// ----------------------------------------------------------------------------
// aligned_stack_allocator
// Stack allocator over a pool at a configured base address, with an
// adjustment-byte side store so that aligned blocks can be released.
// ----------------------------------------------------------------------------
// Usage:
//   Command channel: drive req_* and raise start; the item is taken at the
//   clock edge where start is high and busy is low. busy is high for the one
//   cycle in which the item executes.
//   Result channel: rsp_valid strobes for one cycle with rsp_status,
//   rsp_result_address, rsp_top_offset and rsp_marker_offset. The receiver
//   cannot stall it; every item gives exactly one result.
//   Result: the item executes in S_EXEC and its result is registered at its
//   end. A new item is taken only after the previous one has executed, for
//   every command, as set by the adjustment RAM's registered read: the read
//   is issued at the accept edge and its data is used in the execute cycle,
//   which also updates the top offset that the next item needs.
//   CSR channel: csr_ready is always high; index 0 is base_address and
//   index 1 is pool_size. Write only while no item is in flight.
//   Reset (synchronous): top offset and marker clear, base_address to zero,
//   pool_size to 4096. The adjustment store is not cleared: the user must
//   read an entry only after an allocate wrote it; the block does not enforce it.
// ----------------------------------------------------------------------------
module aligned_stack_allocator #(
   parameter int unsigned POOL_BYTES = asa_pkg::POOL_BYTES_DEFAULT
) (
   input  logic                            clock,
   input  logic                            reset,
   // Command channel
   input  logic                            start,
   output logic                            busy,
   input  logic [asa_pkg::CMD_W-1:0]       req_command,
   input  logic [asa_pkg::OFF_W-1:0]       req_request_size,
   input  logic [asa_pkg::LG_W-1:0]        req_align_log2,
   input  logic [asa_pkg::ADDR_W-1:0]      req_block_address,
   input  logic [asa_pkg::OFF_W-1:0]       req_marker_value,
   // Result channel
   output logic                            rsp_valid,
   output logic [asa_pkg::STAT_W-1:0]      rsp_status,
   output logic [asa_pkg::ADDR_W-1:0]      rsp_result_address,
   output logic [asa_pkg::OFF_W-1:0]       rsp_top_offset,
   output logic [asa_pkg::OFF_W-1:0]       rsp_marker_offset,
   // CSR channel
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [asa_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [asa_pkg::ADDR_W-1:0]      csr_data
);

   localparam int unsigned AW       = $clog2(POOL_BYTES);
   localparam int unsigned SumW     = (AW > asa_pkg::OFF_W + 1) ? AW : asa_pkg::OFF_W + 1;
   localparam int unsigned OffMax   = (1 << asa_pkg::OFF_W) - 1;
   localparam int unsigned PoolLim  = (POOL_BYTES < OffMax) ? POOL_BYTES : OffMax;
   localparam logic [asa_pkg::OFF_W-1:0] PoolLimit = asa_pkg::OFF_W'(PoolLim);

   typedef enum logic [1:0] {
      S_IDLE = 2'b01,
      S_EXEC = 2'b10
   } state_type;

   // Registers
   state_type                        state_ff, state_in;
   logic [asa_pkg::ADDR_W-1:0]       base_ff;
   logic [asa_pkg::OFF_W-1:0]        pool_size_ff;
   logic [asa_pkg::OFF_W-1:0]        top_ff, top_in;
   logic [asa_pkg::OFF_W-1:0]        marker_ff, marker_in;
   logic [asa_pkg::CMD_W-1:0]        cmd_ff;
   logic [asa_pkg::OFF_W-1:0]        size_ff;
   logic [asa_pkg::LG_W-1:0]         lg_ff;
   logic [asa_pkg::ADDR_W-1:0]       addr_ff;
   logic [asa_pkg::OFF_W-1:0]        mark_ff;
   logic                             rsp_valid_ff;
   logic [asa_pkg::STAT_W-1:0]       status_ff, status_in;
   logic [asa_pkg::ADDR_W-1:0]       result_ff, result_in;

   // Datapath
   logic                             accept;
   logic [asa_pkg::ADDR_W-1:0]       rd_dist;
   logic [asa_pkg::ADDR_W-1:0]       rd_index;
   logic [asa_pkg::OFF_W-1:0]        psize;
   logic [asa_pkg::LG_W-1:0]         lg_sat;
   logic [asa_pkg::ADJ_W-1:0]        align;
   logic [asa_pkg::OFF_W+1:0]        need;
   logic [asa_pkg::ADDR_W-1:0]       raw;
   logic [asa_pkg::ADJ_W-1:0]        alloc_adj;
   logic [SumW-1:0]                  wr_sum;
   logic [asa_pkg::ADDR_W-1:0]       blk_off;
   logic                             blk_off_ok;
   logic [asa_pkg::ADJ_W-1:0]        stored_adj;
   logic [asa_pkg::ADJ_W-1:0]        free_adj;
   logic [asa_pkg::ADDR_W-1:0]       free_top;
   logic                             ram_wr_en;
   logic [asa_pkg::ADJ_W-1:0]        ram_rd_data;

   assign accept    = start && !busy;
   assign busy      = (state_ff == S_EXEC);
   assign csr_ready = 1'b1;

   // Issue the adjustment read at the accept edge
   assign rd_dist  = req_block_address - base_ff;
   assign rd_index = rd_dist - 32'd1;

   // Effective pool size
   assign psize = (pool_size_ff > PoolLimit) ? PoolLimit : pool_size_ff;

   // Allocate: align base + top upward by 1 to align bytes
   assign lg_sat    = (lg_ff > asa_pkg::MAX_ALIGN_LOG2) ? asa_pkg::MAX_ALIGN_LOG2 : lg_ff;
   assign align     = asa_pkg::ADJ_W'(1) << lg_sat;
   assign need      = (asa_pkg::OFF_W+2)'(top_ff) + (asa_pkg::OFF_W+2)'(size_ff)
                    + (asa_pkg::OFF_W+2)'(align);
   assign raw       = base_ff + asa_pkg::ADDR_W'(top_ff);
   assign alloc_adj = align - (raw[asa_pkg::ADJ_W-1:0] & (align - asa_pkg::ADJ_W'(1)));
   assign wr_sum    = SumW'(top_ff) + SumW'(alloc_adj) - SumW'(1);

   // Deallocate: check the block offset and the stored adjustment
   assign blk_off    = addr_ff - base_ff;
   assign blk_off_ok = (blk_off != '0) && (blk_off <= asa_pkg::ADDR_W'(top_ff));
   assign stored_adj = ram_rd_data;
   assign free_adj   = blk_off_ok ? stored_adj : '0;
   assign free_top   = blk_off - asa_pkg::ADDR_W'(free_adj);

   // Execute one item
   always_comb begin
      top_in    = top_ff;
      marker_in = marker_ff;
      status_in = asa_pkg::ST_OK;
      result_in = '0;
      ram_wr_en = 1'b0;
      if (state_ff == S_EXEC) begin
         case (asa_pkg::cmd_type'(cmd_ff))
            asa_pkg::CMD_ALLOC: begin
               if (need > (asa_pkg::OFF_W+2)'(psize)) begin
                  status_in = asa_pkg::ST_NO_SPACE;
               end else begin
                  result_in = raw + asa_pkg::ADDR_W'(alloc_adj);
                  ram_wr_en = 1'b1;
                  top_in    = top_ff + size_ff + asa_pkg::OFF_W'(alloc_adj);
               end
            end
            asa_pkg::CMD_DEALLOC: begin
               if (free_adj == '0 || asa_pkg::ADDR_W'(free_adj) > blk_off) begin
                  status_in = asa_pkg::ST_BAD_ADDR;
               end else begin
                  top_in = free_top[asa_pkg::OFF_W-1:0];
               end
            end
            asa_pkg::CMD_RESET: begin
               top_in    = '0;
               marker_in = '0;
            end
            asa_pkg::CMD_MARK: begin
               marker_in = top_ff;
            end
            asa_pkg::CMD_FREE_MARK: begin
               top_in = marker_ff;
            end
            asa_pkg::CMD_SET_MARK: begin
               if (mark_ff > psize) begin
                  status_in = asa_pkg::ST_BAD_MARK;
               end else begin
                  marker_in = mark_ff;
               end
            end
            default: begin
               status_in = asa_pkg::ST_OK;
            end
         endcase
      end
   end

   // Sequencer
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Control state and configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         top_ff       <= '0;
         marker_ff    <= '0;
         rsp_valid_ff <= 1'b0;
         base_ff      <= asa_pkg::BASE_ADDRESS_RESET;
         pool_size_ff <= asa_pkg::POOL_SIZE_RESET;
      end else begin
         state_ff     <= state_in;
         top_ff       <= top_in;
         marker_ff    <= marker_in;
         rsp_valid_ff <= (state_ff == S_EXEC);
         if (csr_valid && csr_ready) begin
            unique case (asa_pkg::csr_index_type'(csr_index))
               asa_pkg::CSR_BASE_ADDRESS: base_ff      <= csr_data;
               asa_pkg::CSR_POOL_SIZE:    pool_size_ff <= csr_data[asa_pkg::OFF_W-1:0];
               default:                   base_ff      <= base_ff;
            endcase
         end
      end
   end

   // Hold the accepted item and the result payload
   always_ff @(posedge clock) begin
      if (accept) begin
         cmd_ff  <= req_command;
         size_ff <= req_request_size;
         lg_ff   <= req_align_log2;
         addr_ff <= req_block_address;
         mark_ff <= req_marker_value;
      end
      if (state_ff == S_EXEC) begin
         status_ff <= status_in;
         result_ff <= result_in;
      end
   end

   // Adjustment store
   asa_ram #(
      .WIDTH (asa_pkg::ADJ_W),
      .DEPTH (POOL_BYTES)
   ) u_adjust_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (wr_sum[AW-1:0]),
      .wr_data (alloc_adj),
      .rd_en   (accept),
      .rd_addr (rd_index[AW-1:0]),
      .rd_data (ram_rd_data)
   );

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_status         = status_ff;
   assign rsp_result_address = result_ff;
   assign rsp_top_offset     = top_ff;
   assign rsp_marker_offset  = marker_ff;

endmodule

// ===== rtl/asa_checker.sv =====
// ----------------------------------------------------------------------------
// asa_checker
// Port-level checks of the aligned stack allocator: command/result timing,
// the result payload of failed commands and the idle state after reset.
// ----------------------------------------------------------------------------
module asa_checker (
   input logic                        clock,
   input logic                        reset,
   input logic                        start,
   input logic                        busy,
   input logic                        rsp_valid,
   input logic [asa_pkg::STAT_W-1:0]  rsp_status,
   input logic [asa_pkg::ADDR_W-1:0]  rsp_result_address
);

   // Every accepted item gives its result strobe after its execute state
   a_rsp_latency: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> ##1 rsp_valid)
      else $error("result strobe missing two cycles after accept");

   // Execution holds busy for one cycle only
   a_busy_one: assert property (@(posedge clock) disable iff (reset)
      busy |=> !busy)
      else $error("busy held longer than one cycle");

   // Results never come in consecutive cycles
   a_rsp_spacing: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobes in consecutive cycles");

   // A failed command grants no address
   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status != asa_pkg::ST_OK) |-> (rsp_result_address == '0))
      else $error("failed command returned an address");

   // Leaving reset finds the block idle with no result
   a_reset_idle: assert property (@(posedge clock)
      (!reset && $past(reset)) |-> (!busy && !rsp_valid))
      else $error("block not idle after reset");

endmodule

bind aligned_stack_allocator asa_checker u_asa_checker (
   .clock              (clock),
   .reset              (reset),
   .start              (start),
   .busy               (busy),
   .rsp_valid          (rsp_valid),
   .rsp_status         (rsp_status),
   .rsp_result_address (rsp_result_address)
);

// ===== sim/asa_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// asa_tb_checker
// Watches the command, result and CSR channels of the aligned stack
// allocator, predicts the outcome of every accepted item from its own copy of
// the allocator state and compares each result, field by field, in order.
// ----------------------------------------------------------------------------
module asa_tb_checker
   import asa_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic                  busy,
   input  logic [CMD_W-1:0]      req_command,
   input  logic [OFF_W-1:0]      req_request_size,
   input  logic [LG_W-1:0]       req_align_log2,
   input  logic [ADDR_W-1:0]     req_block_address,
   input  logic [OFF_W-1:0]      req_marker_value,
   input  logic                  rsp_valid,
   input  logic [STAT_W-1:0]     rsp_status,
   input  logic [ADDR_W-1:0]     rsp_result_address,
   input  logic [OFF_W-1:0]      rsp_top_offset,
   input  logic [OFF_W-1:0]      rsp_marker_offset,
   input  logic                  csr_valid,
   input  logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [ADDR_W-1:0]     csr_data,
   output int unsigned           fail_count,
   output int unsigned           pending_count
);

   localparam int unsigned POOL = POOL_BYTES_DEFAULT;

   typedef struct {
      status_type          status;
      logic [ADDR_W-1:0]   address;
      logic [OFF_W-1:0]    top;
      logic [OFF_W-1:0]    marker;
   } outcome_type;

   outcome_type         pending_outcomes[$];
   logic [ADDR_W-1:0]   base_reg = BASE_ADDRESS_RESET;
   logic [OFF_W-1:0]    pool_reg = POOL_SIZE_RESET;
   int unsigned         top_off;
   int unsigned         marker_off;
   logic [ADJ_W-1:0]    adjust_mem [0:POOL-1];
   int unsigned         errors;

   // Execute one command against the shadow state and return its outcome
   function automatic outcome_type apply_command(
      input logic [CMD_W-1:0]   cmd,
      input logic [OFF_W-1:0]   size,
      input logic [LG_W-1:0]    lg,
      input logic [ADDR_W-1:0]  addr,
      input logic [OFF_W-1:0]   mark
   );
      outcome_type         o;
      int unsigned         live;
      int unsigned         align;
      int unsigned         adj;
      int unsigned         blk_off;
      logic [LG_W-1:0]     lg_sat;
      logic [ADDR_W-1:0]   raw;
      live = (pool_reg > POOL) ? POOL : 32'(pool_reg);
      o.status = ST_OK;
      o.address = '0;
      case (cmd)
         CMD_ALLOC: begin
            lg_sat = (lg > MAX_ALIGN_LOG2) ? MAX_ALIGN_LOG2 : lg;
            align = 1 << lg_sat;
            if (top_off + size + align > live) begin
               o.status = ST_NO_SPACE;
            end else begin
               // bump to the next aligned address, keep the pad just below it
               raw = base_reg + top_off;
               adj = align - (raw & (align - 1));
               o.address = raw + adj;
               if (top_off + adj - 1 < POOL) begin
                  adjust_mem[top_off + adj - 1] = adj[ADJ_W-1:0];
               end
               top_off = top_off + size + adj;
            end
         end
         CMD_DEALLOC: begin
            blk_off = addr - base_reg;
            adj = 0;
            if (blk_off >= 1 && blk_off <= top_off && blk_off - 1 < POOL) begin
               adj = 32'(adjust_mem[blk_off - 1]);
            end
            if (adj == 0 || adj > blk_off) begin
               o.status = ST_BAD_ADDR;
            end else begin
               top_off = blk_off - adj;
            end
         end
         CMD_RESET: begin
            top_off = 0;
            marker_off = 0;
         end
         CMD_MARK: begin
            marker_off = top_off;
         end
         CMD_FREE_MARK: begin
            top_off = marker_off;
         end
         CMD_SET_MARK: begin
            if (mark > live) begin
               o.status = ST_BAD_MARK;
            end else begin
               marker_off = 32'(mark);
            end
         end
         default: begin
         end
      endcase
      o.top = top_off[OFF_W-1:0];
      o.marker = marker_off[OFF_W-1:0];
      return o;
   endfunction

   always @(posedge clock) begin
      outcome_type want;
      if (reset) begin
         pending_outcomes.delete();
         base_reg = BASE_ADDRESS_RESET;
         pool_reg = POOL_SIZE_RESET;
         top_off = 0;
         marker_off = 0;
      end else begin
         // track register writes
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_BASE_ADDRESS: base_reg = csr_data;
               CSR_POOL_SIZE:    pool_reg = csr_data[OFF_W-1:0];
               default: begin
               end
            endcase
         end
         // compare each result with the oldest prediction
         if (rsp_valid) begin
            if (pending_outcomes.size() == 0) begin
               errors++;
               if (errors <= 10) begin
                  $display("unexpected result at %0t: status %0d addr %h top %0d marker %0d",
                           $time, rsp_status, rsp_result_address, rsp_top_offset,
                           rsp_marker_offset);
               end
            end else begin
               want = pending_outcomes.pop_front();
               if (rsp_status !== want.status || rsp_result_address !== want.address ||
                   rsp_top_offset !== want.top || rsp_marker_offset !== want.marker) begin
                  errors++;
                  if (errors <= 10) begin
                     $display("mismatch at %0t (expected/actual): status %0d/%0d addr %h/%h",
                              $time, want.status, rsp_status, want.address,
                              rsp_result_address);
                     $display("   top %0d/%0d marker %0d/%0d",
                              want.top, rsp_top_offset, want.marker, rsp_marker_offset);
                  end
               end
            end
         end
         // predict each accepted item
         if (start && !busy) begin
            pending_outcomes.push_back(apply_command(req_command, req_request_size,
                                                     req_align_log2, req_block_address,
                                                     req_marker_value));
         end
      end
      fail_count <= errors;
      pending_count <= pending_outcomes.size();
   end

endmodule

// ===== sim/aligned_stack_allocator_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aligned_stack_allocator_tb
// Drives the allocator with a directed list of corner items and then with
// random command mixes under several pool settings and sender idle rates;
// the checker beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
module aligned_stack_allocator_tb;
   import asa_pkg::*;

   localparam int unsigned     CYCLE_LIMIT   = 200000;
   localparam int unsigned     SETTING_ITEMS = 175;
   localparam int unsigned     POOL          = POOL_BYTES_DEFAULT;
   localparam logic [CMD_W-1:0] CMD_SPARE_LO = 3'd6;
   localparam logic [CMD_W-1:0] CMD_SPARE_HI = 3'd7;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  start = 1'b0;
   logic                  busy;
   logic [CMD_W-1:0]      req_command = CMD_ALLOC;
   logic [OFF_W-1:0]      req_request_size = '0;
   logic [LG_W-1:0]       req_align_log2 = '0;
   logic [ADDR_W-1:0]     req_block_address = '0;
   logic [OFF_W-1:0]      req_marker_value = '0;
   logic                  rsp_valid;
   logic [STAT_W-1:0]     rsp_status;
   logic [ADDR_W-1:0]     rsp_result_address;
   logic [OFF_W-1:0]      rsp_top_offset;
   logic [OFF_W-1:0]      rsp_marker_offset;
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index = CSR_BASE_ADDRESS;
   logic [ADDR_W-1:0]     csr_data = '0;
   int unsigned           fail_count;
   int unsigned           pending_count;

   // stimulus bookkeeping
   int unsigned           cycle_count = 0;
   int unsigned           idle_pct = 0;
   logic [ADDR_W-1:0]     base_shadow = BASE_ADDRESS_RESET;
   int unsigned           live_pool = POOL;
   logic [CMD_W-1:0]      issued_cmds[$];
   int unsigned           live_blocks[$];
   int unsigned           written_list[$];
   bit                    offset_written [0:POOL-1];

   aligned_stack_allocator u_top (.*);

   asa_tb_checker u_checker (.*);

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // end the run on a hang
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   // learn granted offsets so that deallocates only read written pad bytes
   always @(posedge clock) begin
      logic [CMD_W-1:0]  cmd;
      int unsigned       grant_off;
      if (rsp_valid && issued_cmds.size() != 0) begin
         cmd = issued_cmds.pop_front();
         if (cmd == CMD_ALLOC && rsp_status == ST_OK) begin
            grant_off = rsp_result_address - base_shadow;
            if (grant_off >= 1 && grant_off <= POOL) begin
               if (!offset_written[grant_off - 1]) begin
                  offset_written[grant_off - 1] = 1'b1;
                  written_list.push_back(grant_off);
               end
               live_blocks.push_back(grant_off);
            end
         end
      end
   end

   // Present one item after a random idle gap and hold it until accepted
   task automatic send_item(
      input logic [CMD_W-1:0]   cmd,
      input logic [OFF_W-1:0]   size,
      input logic [LG_W-1:0]    lg,
      input logic [ADDR_W-1:0]  addr,
      input logic [OFF_W-1:0]   mark
   );
      while ($urandom_range(99) < idle_pct) begin
         start = 1'b0;
         @(negedge clock);
      end
      start = 1'b1;
      req_command = cmd;
      req_request_size = size;
      req_align_log2 = lg;
      req_block_address = addr;
      req_marker_value = mark;
      @(posedge clock);
      while (busy) @(posedge clock);
      issued_cmds.push_back(cmd);
      if (cmd == CMD_RESET) begin
         live_blocks.delete();
      end
      @(negedge clock);
   endtask

   // Hold off the sender until every predicted result has come back
   task automatic drain_items();
      start = 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic write_csr(input csr_index_type idx, input logic [ADDR_W-1:0] data);
      csr_valid = 1'b1;
      csr_index = idx;
      csr_data = data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   initial begin
      logic [CMD_W-1:0]    cmd;
      logic [OFF_W-1:0]    size;
      logic [LG_W-1:0]     lg;
      logic [ADDR_W-1:0]   addr;
      logic [OFF_W-1:0]    mark;
      logic [ADDR_W-1:0]   base_val;
      logic [ADDR_W-1:0]   pool_val;
      int unsigned         pick;
      int unsigned         off;
      int unsigned         idle_plan [3] = '{0, 80, 32};

      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed corners at the reset pool settings
      send_item(CMD_ALLOC, 13'd100, 3'd3, '0, '0);
      send_item(CMD_ALLOC, 13'h1FFF, 3'd0, '1, '1);
      send_item(CMD_ALLOC, 13'd0, 3'd7, '0, '0);
      send_item(CMD_MARK, '0, '0, '0, '0);
      send_item(CMD_ALLOC, 13'd37, 3'd5, '0, '0);
      drain_items();
      off = live_blocks.pop_back();
      send_item(CMD_DEALLOC, '0, '0, base_shadow + off, '0);
      // address at the pool base, above top and far out of range
      send_item(CMD_DEALLOC, '0, '0, base_shadow, '0);
      send_item(CMD_DEALLOC, '0, '0, base_shadow + 32'd160, '0);
      send_item(CMD_DEALLOC, '1, '1, 32'hFFFF_FFFF, '1);
      send_item(CMD_ALLOC, 13'd500, 3'd2, '0, '0);
      send_item(CMD_FREE_MARK, '0, '0, '0, '0);
      send_item(CMD_SET_MARK, '0, '0, '0, 13'h1FFF);
      send_item(CMD_SET_MARK, '0, '0, '0, 13'd4096);
      send_item(CMD_SET_MARK, '0, '0, '0, 13'd4097);
      send_item(CMD_SPARE_LO, '1, '1, '1, '1);
      send_item(CMD_SPARE_HI, '1, '1, '1, '1);
      send_item(CMD_RESET, '0, '0, '0, '0);
      // exact fit of the whole pool, then one byte too many
      send_item(CMD_ALLOC, 13'd3968, 3'd7, '0, '0);
      send_item(CMD_ALLOC, 13'd0, 3'd0, '0, '0);
      drain_items();
      off = live_blocks.pop_back();
      send_item(CMD_DEALLOC, '0, '0, base_shadow + off, '0);
      send_item(CMD_SET_MARK, '0, '0, '0, 13'd0);
      send_item(CMD_ALLOC, 13'd3969, 3'd7, '0, '0);

      // random mixes under several pool settings
      for (int s = 0; s < 6; s++) begin
         drain_items();
         case (s)
            0: begin
               base_val = 32'h0000_1000;
               pool_val = 32'd4096;
            end
            1: begin
               base_val = 32'h8000_0000;
               pool_val = 32'h0000_1FFF;
            end
            2: begin
               // pool straddles the top of the address space
               base_val = 32'hFFFF_FFC0;
               pool_val = 32'd300;
            end
            3: begin
               base_val = $urandom;
               pool_val = 32'd0;
            end
            4: begin
               base_val = 32'hFFFF_FFFF;
               pool_val = 32'd4095;
            end
            default: begin
               base_val = $urandom;
               pool_val = ($urandom & 32'hFFFF_E000) | 32'd2000;
            end
         endcase
         write_csr(CSR_BASE_ADDRESS, base_val);
         write_csr(CSR_POOL_SIZE, pool_val);
         base_shadow = base_val;
         live_pool = (pool_val[OFF_W-1:0] > POOL) ? POOL : pool_val[OFF_W-1:0];
         if ($urandom_range(1) == 1) begin
            send_item(CMD_RESET, '0, '0, '0, '0);
         end

         for (int k = 0; k < SETTING_ITEMS; k++) begin
            idle_pct = idle_plan[(s + k / 60) % 3];
            pick = $urandom_range(99);
            // mostly small blocks, a few large and a few arbitrary sizes
            off = $urandom_range(99);
            if (off < 80) begin
               size = OFF_W'($urandom_range(0, 64));
            end else if (off < 95) begin
               size = OFF_W'($urandom_range(0, 512));
            end else begin
               size = OFF_W'($urandom_range(0, 8191));
            end
            lg = LG_W'($urandom_range(0, 7));
            addr = $urandom;
            mark = OFF_W'($urandom_range(0, 8191));
            cmd = CMD_ALLOC;
            if (pick < 45) begin
               cmd = CMD_ALLOC;
            end else if (pick < 70) begin
               // release the most recent known block
               if (live_blocks.size() != 0) begin
                  cmd = CMD_DEALLOC;
                  addr = base_shadow + live_blocks.pop_back();
               end
            end else if (pick < 75) begin
               // release the pool base address, one beyond the pool, or a stale block
               cmd = CMD_DEALLOC;
               case ($urandom_range(2))
                  0: addr = base_shadow;
                  1: addr = base_shadow + $urandom_range(POOL + 1, 32'hFFFF_FFFF);
                  default: begin
                     addr = base_shadow;
                     if (written_list.size() != 0) begin
                        addr = base_shadow +
                               written_list[$urandom_range(written_list.size() - 1)];
                     end
                  end
               endcase
            end else if (pick < 82) begin
               cmd = CMD_MARK;
            end else if (pick < 89) begin
               cmd = CMD_FREE_MARK;
            end else if (pick < 95) begin
               cmd = CMD_SET_MARK;
               if ($urandom_range(9) < 7) begin
                  mark = OFF_W'($urandom_range(0, live_pool));
               end
            end else if (pick < 97) begin
               cmd = CMD_RESET;
            end else begin
               cmd = CMD_W'($urandom_range(CMD_SPARE_LO, CMD_SPARE_HI));
            end
            send_item(cmd, size, lg, addr, mark);
         end
      end

      drain_items();
      repeat (4) @(posedge clock);
      if (fail_count == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
rtl/asa_pkg.sv
rtl/asa_ram.sv
rtl/aligned_stack_allocator.sv
rtl/asa_checker.sv
sim/asa_checker.sv
sim/aligned_stack_allocator_tb.sv
